>>> rtl/matrix_keypad_event_debouncer_top_defines.svh
// Assertion macros used by the keypad debouncer checker file
`ifndef MATRIX_KEYPAD_EVENT_DEBOUNCER_TOP_DEFINES_SVH
`define MATRIX_KEYPAD_EVENT_DEBOUNCER_TOP_DEFINES_SVH

// same-cycle implication, reset-qualified
`define MKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset-qualified
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mkd_pkg.sv
// Package: sizes, codes and controller/datapath bundles of the keypad debouncer
`default_nettype none

package mkd_pkg;

  localparam int ROWS     = 3;
  localparam int COLS     = 3;
  localparam int NPOS     = ROWS * COLS;
  localparam int POS_W    = (NPOS > 1) ? $clog2(NPOS) : 1;
  localparam int DEB_W    = 16;
  localparam int TIME_W   = 32;
  localparam int KEY_ID_W = 4;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_LONG    = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] EV_SHORT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK     = 2'd2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd100;
  localparam logic [TIME_W-1:0] LONG_RST     = 32'd5000;
  localparam logic [NPOS-1:0]   MASK_RST     = NPOS'(383);

  typedef struct packed {
    logic start;
    logic step;
    logic adv;
    logic push2;
    logic flush;
  } mkd_cmd_t;

  typedef struct packed {
    logic has_ev;
    logic has_sec;
    logic can_push;
    logic last_pos;
    logic pend_v;
    logic out_free;
  } mkd_stat_t;

endpackage

`default_nettype wire

>>> rtl/mkd_ifs.sv
// Channel interfaces: scan input, event output and register write
`default_nettype none

interface mkd_in_if;
  logic                      valid;
  logic                      ready;
  logic [mkd_pkg::NPOS-1:0]   position_levels;
  logic [mkd_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output position_levels, output now_ms, input ready);
  modport sink   (input valid, input position_levels, input now_ms, output ready);
endinterface

interface mkd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mkd_pkg::KEY_ID_W-1:0] key_id;
  logic [mkd_pkg::KIND_W-1:0]   event_kind;
  logic [mkd_pkg::TIME_W-1:0]   held_ms;
  logic                        last;

  modport source (output valid, output key_id, output event_kind, output held_ms,
                  output last, input ready);
  modport sink   (input valid, input key_id, input event_kind, input held_ms,
                  input last, output ready);
endinterface

interface mkd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mkd_pkg::CFG_IDX_W-1:0] index;
  logic [mkd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/mkd_ctrl.sv
// Controller: walks the positions of one scan and sequences event output
`default_nettype none

module mkd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mkd_pkg::mkd_stat_t st,
  output mkd_pkg::mkd_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_EMIT2 = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!st.has_ev || st.can_push) begin
          cmd.step = 1'b1;
          cmd.adv  = !st.has_sec;
          if (st.has_sec) begin
            state_nxt = S_EMIT2;
          end else if (st.last_pos) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_EMIT2: begin
        if (st.can_push) begin
          cmd.push2 = 1'b1;
          cmd.adv   = 1'b1;
          state_nxt = st.last_pos ? S_FLUSH : S_EVAL;
        end
      end
      S_FLUSH: begin
        if (!st.pend_v) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mkd_dp.sv
// Datapath: key state, registers, event decode, pending and output words
`default_nettype none

module mkd_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [mkd_pkg::NPOS-1:0]   levels,
  input  wire logic [mkd_pkg::TIME_W-1:0] now_ms,
  input  wire mkd_pkg::mkd_cmd_t          cmd,
  output mkd_pkg::mkd_stat_t              st,
  mkd_cfg_if.sink                        cfg_if,
  mkd_out_if.source                      out_if
);

  logic [mkd_pkg::DEB_W-1:0]  deb_r;
  logic [mkd_pkg::TIME_W-1:0] long_r;
  logic [mkd_pkg::NPOS-1:0]   mask_r;

  logic [mkd_pkg::NPOS-1:0]   lev_r;
  logic [mkd_pkg::TIME_W-1:0] now_r;
  logic [mkd_pkg::POS_W-1:0]  pos_r;
  logic [mkd_pkg::KEY_ID_W-1:0] id_r;

  logic [mkd_pkg::NPOS-1:0]   raw_r;
  logic [mkd_pkg::NPOS-1:0]   conf_r;
  logic [mkd_pkg::NPOS-1:0]   lrep_r;
  logic [mkd_pkg::TIME_W-1:0] dbs_r [mkd_pkg::NPOS];
  logic [mkd_pkg::TIME_W-1:0] pst_r [mkd_pkg::NPOS];

  logic [mkd_pkg::KEY_ID_W-1:0] sec_id_r;
  logic [mkd_pkg::KIND_W-1:0]   sec_kind_r;
  logic [mkd_pkg::TIME_W-1:0]   sec_dur_r;

  logic                         pend_v_r;
  logic [mkd_pkg::KEY_ID_W-1:0] pend_id_r;
  logic [mkd_pkg::KIND_W-1:0]   pend_kind_r;
  logic [mkd_pkg::TIME_W-1:0]   pend_dur_r;

  logic                         out_v_r;
  logic [mkd_pkg::KEY_ID_W-1:0] out_id_r;
  logic [mkd_pkg::KIND_W-1:0]   out_kind_r;
  logic [mkd_pkg::TIME_W-1:0]   out_dur_r;
  logic                         out_last_r;

  logic                         en;
  logic                         down;
  logic                         raw;
  logic                         conf;
  logic                         lrep;
  logic [mkd_pkg::TIME_W-1:0]   db_diff;
  logic [mkd_pkg::TIME_W-1:0]   held_raw;
  logic [mkd_pkg::TIME_W-1:0]   held;
  logic                         conf_now;
  logic                         long_fire;
  logic                         rel;
  logic                         short_fire;
  logic [mkd_pkg::KEY_ID_W-1:0] id_cur;
  logic [mkd_pkg::KIND_W-1:0]   first_kind;
  logic [mkd_pkg::KIND_W-1:0]   sec_kind;
  logic                         out_free;
  logic                         push_en;
  logic [mkd_pkg::KEY_ID_W-1:0] push_id;
  logic [mkd_pkg::KIND_W-1:0]   push_kind;
  logic [mkd_pkg::TIME_W-1:0]   push_dur;

  assign en       = mask_r[pos_r];
  assign down     = lev_r[pos_r];
  assign raw      = raw_r[pos_r];
  assign conf     = conf_r[pos_r];
  assign lrep     = lrep_r[pos_r];
  assign db_diff  = now_r - dbs_r[pos_r];
  assign held_raw = now_r - pst_r[pos_r];

  assign conf_now   = down && raw && !conf &&
                      (db_diff >= mkd_pkg::TIME_W'(deb_r));
  assign held       = conf_now ? '0 : held_raw;
  assign long_fire  = down && raw && (conf || conf_now) && !lrep && (held >= long_r);
  assign rel        = !down && raw && conf;
  assign short_fire = rel && !lrep;
  assign id_cur     = id_r + 1'b1;

  assign first_kind = conf_now  ? mkd_pkg::EV_PRESS :
                      long_fire ? mkd_pkg::EV_LONG  : mkd_pkg::EV_RELEASE;
  assign sec_kind   = down ? mkd_pkg::EV_LONG : mkd_pkg::EV_SHORT;

  assign out_free = !out_v_r || out_if.ready;

  assign st.has_ev   = en && (conf_now || long_fire || rel);
  assign st.has_sec  = en && ((conf_now && long_fire) || short_fire);
  assign st.can_push = !pend_v_r || out_free;
  assign st.last_pos = (pos_r == mkd_pkg::POS_W'(mkd_pkg::NPOS - 1));
  assign st.pend_v   = pend_v_r;
  assign st.out_free = out_free;

  assign push_en   = (cmd.step && st.has_ev) || cmd.push2;
  assign push_id   = cmd.push2 ? sec_id_r   : id_cur;
  assign push_kind = cmd.push2 ? sec_kind_r : first_kind;
  assign push_dur  = cmd.push2 ? sec_dur_r  : held;

  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = out_v_r;
  assign out_if.key_id     = out_id_r;
  assign out_if.event_kind = out_kind_r;
  assign out_if.held_ms    = out_dur_r;
  assign out_if.last       = out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= mkd_pkg::DEBOUNCE_RST;
      long_r <= mkd_pkg::LONG_RST;
      mask_r <= mkd_pkg::MASK_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        mkd_pkg::REG_DEBOUNCE: deb_r  <= cfg_if.data[mkd_pkg::DEB_W-1:0];
        mkd_pkg::REG_LONG:     long_r <= cfg_if.data[mkd_pkg::TIME_W-1:0];
        mkd_pkg::REG_MASK:     mask_r <= mkd_pkg::NPOS'(cfg_if.data);
        default: begin
        end
      endcase
    end
  end

  // scan word and walk counters
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lev_r <= levels;
      now_r <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      id_r  <= '0;
    end else begin
      if (cmd.start) begin
        pos_r <= '0;
        id_r  <= '0;
      end else begin
        if (cmd.adv) begin
          pos_r <= pos_r + 1'b1;
        end
        if (cmd.step && en) begin
          id_r <= id_cur;
        end
      end
    end
  end

  // per-key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= '0;
      conf_r <= '0;
      lrep_r <= '0;
      for (int i = 0; i < mkd_pkg::NPOS; i++) begin
        dbs_r[i] <= '0;
        pst_r[i] <= '0;
      end
    end else if (cmd.step && en) begin
      if (down) begin
        if (!raw) begin
          dbs_r[pos_r]  <= now_r;
          raw_r[pos_r]  <= 1'b1;
          conf_r[pos_r] <= 1'b0;
        end else begin
          if (conf_now) begin
            pst_r[pos_r]  <= now_r;
            conf_r[pos_r] <= 1'b1;
          end
          if (long_fire) begin
            lrep_r[pos_r] <= 1'b1;
          end
        end
      end else begin
        raw_r[pos_r]  <= 1'b0;
        dbs_r[pos_r]  <= '0;
        conf_r[pos_r] <= 1'b0;
        lrep_r[pos_r] <= 1'b0;
      end
    end
  end

  // hold second event of a key
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      sec_id_r   <= id_cur;
      sec_kind_r <= sec_kind;
      sec_dur_r  <= held;
    end
  end

  // pending and output words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (push_en) begin
        pend_v_r <= 1'b1;
        out_v_r  <= pend_v_r || (out_v_r && !out_if.ready);
      end else if (cmd.flush) begin
        out_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
      end else if (out_v_r && out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      pend_id_r   <= push_id;
      pend_kind_r <= push_kind;
      pend_dur_r  <= push_dur;
    end
    if ((push_en && pend_v_r) || cmd.flush) begin
      out_id_r   <= pend_id_r;
      out_kind_r <= pend_kind_r;
      out_dur_r  <= pend_dur_r;
      out_last_r <= cmd.flush;
    end
  end

endmodule

`default_nettype wire

>>> rtl/matrix_keypad_event_debouncer_top.sv
// Top level of the matrix keypad event debouncer
//
// Takes one key-matrix scan word (pressed levels plus a millisecond timestamp)
// and returns its PRESS, LONG, RELEASE and SHORT event words in position order,
// the final one of a scan marked by last; a scan with no events returns none.
// Positions are visited one per cycle by a single shared compare unit while
// the output side does not stall; a key that yields two events passes
// through the EMIT2 state for its second word. The next scan is accepted as
// soon as the last word sits in the output register. Register writes are
// taken at any time and belong between scans.
`default_nettype none

module matrix_keypad_event_debouncer_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mkd_in_if.sink     in_if,
  mkd_out_if.source  out_if,
  mkd_cfg_if.sink    cfg_if
);

  mkd_pkg::mkd_cmd_t  cmd;
  mkd_pkg::mkd_stat_t st;
  logic               in_ready;

  assign in_if.ready = in_ready;

  mkd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mkd_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .levels (in_if.position_levels),
    .now_ms (in_if.now_ms),
    .cmd    (cmd),
    .st     (st),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

>>> rtl/mkd_checker.sv
// Port checker for the keypad debouncer and its bind to the top level
`default_nettype none
`include "matrix_keypad_event_debouncer_top_defines.svh"

module mkd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [mkd_pkg::KEY_ID_W-1:0] out_key_id,
  input wire logic [mkd_pkg::KIND_W-1:0]   out_event_kind,
  input wire logic [mkd_pkg::TIME_W-1:0]   out_held_ms,
  input wire logic                        out_last
);

  `MKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_key_id) && $stable(out_event_kind) &&
                   $stable(out_held_ms) && $stable(out_last),
                   "event word changed while stalled")
  `MKD_ASSERT_NOW(a_key_id_range, clk, rst_n, out_valid,
                  (out_key_id != '0) && (out_key_id <= mkd_pkg::KEY_ID_W'(mkd_pkg::NPOS)),
                  "key id out of range")
  `MKD_ASSERT_NOW(a_press_zero, clk, rst_n,
                  out_valid && (out_event_kind == mkd_pkg::EV_PRESS), out_held_ms == '0,
                  "press word with nonzero duration")
  `MKD_ASSERT_NEXT(a_busy_after_scan, clk, rst_n, in_valid && in_ready, !in_ready,
                   "scan accepted while previous scan in progress")

endmodule

bind matrix_keypad_event_debouncer_top mkd_checker u_mkd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_key_id     (out_if.key_id),
  .out_event_kind (out_if.event_kind),
  .out_held_ms    (out_if.held_ms),
  .out_last       (out_if.last)
);

`default_nettype wire
